/* hw/rtl/rs485s_pkg.sv */
// package for the rs485 slave frame engine
// holds command codes, register indices, payload types and the crc byte function
// no dependencies
`default_nettype none
package rs485s_pkg;

   localparam int RxDepthDefault = 32;
   localparam int TxDepthDefault = 32;

   typedef enum logic [2:0] {
      CMD_RX_BYTE = 3'd0,
      CMD_TICK    = 3'd1,
      CMD_POLL    = 3'd2,
      CMD_SEND    = 3'd3,
      CMD_TX_RDY  = 3'd4,
      CMD_WR_TX   = 3'd5,
      CMD_RD_RX   = 3'd6,
      CMD_NOP     = 3'd7
   } cmd_type;

   localparam logic [1:0] CSR_NODE_ADDR = 2'd0;
   localparam logic [1:0] CSR_ANS_TMO   = 2'd1;
   localparam logic [1:0] CSR_RX_TMO    = 2'd2;
   localparam logic [1:0] CSR_TURN      = 2'd3;

   localparam logic [7:0]  STX_BYTE  = 8'h02;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [6:0]  EXT_ADDR  = 7'd126;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data;
      logic [4:0] index;
      logic [5:0] answer_length;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_byte_valid;
      logic       transmitter_active;
      logic       bus_drive;
      logic       request_waiting;
      logic [7:0] request_length;
      logic [7:0] read_byte;
   } rsp_type;

   // memory access requests from the control engine to the buffers
   typedef struct packed {
      logic       rx_we;
      logic [7:0] rx_waddr;
      logic       rx_re;
      logic [7:0] rx_raddr;
      logic       tx_we;
      logic [7:0] tx_waddr;
      logic       tx_re;
      logic [7:0] tx_raddr;
      logic [7:0] wdata;
   } mem_req_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/rs485_slave_frame_protocol.sv */
// rs485 slave frame engine, top level
// path: an accepted item passes the engine step into stage 1, then the registered buffer read
// is merged into the output register, which holds the result until it is taken
// throughput: one item per cycle sustained; a stalled result holds the whole pipe
// reset: synchronous, active high; buffers hold no reset and read undefined until written
`default_nettype none
module rs485_slave_frame_protocol #(
   parameter int RX_BUFFER_DEPTH = rs485s_pkg::RxDepthDefault,
   parameter int TX_BUFFER_DEPTH = rs485s_pkg::TxDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[2:0], data[10:3], index[15:11], answer_length[21:16], zero pad[23:22]
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tx_byte[7:0], tx_byte_valid[8], transmitter_active[9], bus_drive[10],
   // request_waiting[11], request_length[19:12], read_byte[27:20], zero pad[31:28]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);
   rs485s_pkg::req_type     req;
   rs485s_pkg::rsp_type     ersp;
   rs485s_pkg::mem_req_type mreq;
   logic [7:0]  rx_rdata, tx_rdata;
   logic        go, rd_rx, rd_tx;
   logic        s1_v_ff, s1_rdrx_ff, s1_rdtx_ff;
   rs485s_pkg::rsp_type s1_ff;
   logic        out_v_ff;
   rs485s_pkg::rsp_type out_ff, s1_fix;
   logic        tx_fix_ff;

   assign req.command       = req_tdata[2:0];
   assign req.data          = req_tdata[10:3];
   assign req.index         = req_tdata[15:11];
   assign req.answer_length = req_tdata[21:16];

   // stage 1 moves on whenever the output register is free or emptying
   logic adv;
   assign adv = !out_v_ff || rsp_tready;
   // a tx payload byte read must not overlap a held stage; simple: accept only when advancing
   assign req_tready = adv;
   assign go = req_tvalid && req_tready;

   rs485s_engine #(.RX_DEPTH(RX_BUFFER_DEPTH), .TX_DEPTH(TX_BUFFER_DEPTH)) u_eng (
      .clock, .reset, .go, .req,
      .csr_we, .csr_idx(csr_index), .csr_val(csr_wdata), .csr_hit(1'b1),
      .crc_fix_en(tx_fix_ff), .crc_fix_byte(tx_rdata),
      .mreq, .rsp(ersp), .rd_rx, .rd_tx
   );

   rs485s_bufs #(.RX_DEPTH(RX_BUFFER_DEPTH), .TX_DEPTH(TX_BUFFER_DEPTH)) u_bufs (
      .clock, .mreq, .rx_rdata, .tx_rdata
   );

   always_comb begin
      s1_fix = s1_ff;
      if (s1_rdrx_ff) s1_fix.read_byte = rx_rdata;
      if (s1_rdtx_ff) s1_fix.tx_byte = tx_rdata;
   end

   // the crc of a transmitted payload byte is folded in once, the cycle after its read
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_fix_ff <= 1'b0;
      end else begin
         tx_fix_ff <= go && rd_tx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0; out_v_ff <= 1'b0;
         s1_rdrx_ff <= 1'b0; s1_rdtx_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= go;
         s1_rdrx_ff <= go && rd_rx;
         s1_rdtx_ff <= go && rd_tx;
         out_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= ersp;
         out_ff <= s1_fix;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {4'h0, out_ff.read_byte, out_ff.request_length, out_ff.request_waiting,
                       out_ff.bus_drive, out_ff.transmitter_active, out_ff.tx_byte_valid,
                       out_ff.tx_byte};
endmodule
`default_nettype wire

/* hw/rtl/rs485s_bufs.sv */
// receive and transmit buffer memories with registered read data
// depends on rs485s_pkg
`default_nettype none
module rs485s_bufs #(
   parameter int RX_DEPTH = rs485s_pkg::RxDepthDefault,
   parameter int TX_DEPTH = rs485s_pkg::TxDepthDefault
) (
   input  wire logic                   clock,
   input  wire rs485s_pkg::mem_req_type mreq,
   output logic [7:0]                  rx_rdata,
   output logic [7:0]                  tx_rdata
);
   localparam int RxAw = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int TxAw = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];
   logic [7:0] rx_rdata_ff;
   logic [7:0] tx_rdata_ff;

   always_ff @(posedge clock) begin
      if (mreq.rx_we) rx_mem[mreq.rx_waddr[RxAw-1:0]] <= mreq.wdata;
      if (mreq.rx_re) rx_rdata_ff <= rx_mem[mreq.rx_raddr[RxAw-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mreq.tx_we) tx_mem[mreq.tx_waddr[TxAw-1:0]] <= mreq.wdata;
      if (mreq.tx_re) tx_rdata_ff <= tx_mem[mreq.tx_raddr[TxAw-1:0]];
   end

   assign rx_rdata = rx_rdata_ff;
   assign tx_rdata = tx_rdata_ff;
endmodule
`default_nettype wire

/* hw/rtl/rs485s_engine.sv */
// protocol engine: rx/tx frame sequencing, crc, flags and timers
// depends on rs485s_pkg; drives the buffer memories through a mem_req_type
`default_nettype none
module rs485s_engine #(
   parameter int RX_DEPTH = rs485s_pkg::RxDepthDefault,
   parameter int TX_DEPTH = rs485s_pkg::TxDepthDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    go,
   input  wire rs485s_pkg::req_type     req,
   input  wire logic                    csr_we,
   input  wire logic [1:0]              csr_idx,
   input  wire logic [8:0]              csr_val,
   input  wire logic                    csr_hit,
   input  wire logic                    crc_fix_en,
   input  wire logic [7:0]              crc_fix_byte,
   output rs485s_pkg::mem_req_type      mreq,
   output rs485s_pkg::rsp_type          rsp,
   output logic                         rd_rx,
   output logic                         rd_tx
);
   localparam logic [8:0] RxD = 9'(RX_DEPTH);
   localparam logic [8:0] TxD = 9'(TX_DEPTH);

   logic [8:0]  node_ff, node_in;
   logic [7:0]  atmo_ff, atmo_in, rtmo_ff, rtmo_in, turn_ff, turn_in;
   logic [2:0]  rxph_ff, rxph_in, txph_ff, txph_in;
   logic [15:0] crc_ff, crc_in, rcrc_ff, rcrc_in;
   logic [8:0]  faddr_ff, faddr_in;
   logic [7:0]  flen_ff, flen_in, rxcnt_ff, rxcnt_in;
   logic [5:0]  txcnt_ff, txcnt_in, alen_ff, alen_in;
   logic [7:0]  acc_ff, acc_in;
   logic        f_sync_ff, f_rxsync_ff, f_forme_ff, f_ovr_ff, f_wait_ff, f_proc_ff;
   logic        f_valid_ff, f_abort_ff, f_txa_ff, f_drive_ff;
   logic        f_sync_in, f_rxsync_in, f_forme_in, f_ovr_in, f_wait_in, f_proc_in;
   logic        f_valid_in, f_abort_in, f_txa_in, f_drive_in;
   logic [7:0]  wpt_ff, wpt_in, ant_ff, ant_in, rct_ff, rct_in;
   logic [15:0] crc_cur;
   logic [15:0] crc_upd;
   logic [7:0]  crc_src, txb;
   logic        txv;
   logic        tx_mem_pending;
   logic [8:0]  sum_addr;

   localparam logic [2:0] TX_IDLE = 3'd6;

   always_comb begin
      // fold in the tx payload byte read from memory in the previous cycle
      crc_cur = crc_fix_en ? rs485s_pkg::crc_byte(crc_ff, crc_fix_byte) : crc_ff;
      node_in = node_ff; atmo_in = atmo_ff; rtmo_in = rtmo_ff; turn_in = turn_ff;
      rxph_in = rxph_ff; txph_in = txph_ff; crc_in = crc_cur; rcrc_in = rcrc_ff;
      faddr_in = faddr_ff; flen_in = flen_ff; rxcnt_in = rxcnt_ff; txcnt_in = txcnt_ff;
      alen_in = alen_ff; acc_in = acc_ff;
      f_sync_in = f_sync_ff; f_rxsync_in = f_rxsync_ff; f_forme_in = f_forme_ff;
      f_ovr_in = f_ovr_ff; f_wait_in = f_wait_ff; f_proc_in = f_proc_ff;
      f_valid_in = f_valid_ff; f_abort_in = f_abort_ff; f_txa_in = f_txa_ff;
      f_drive_in = f_drive_ff;
      wpt_in = wpt_ff; ant_in = ant_ff; rct_in = rct_ff;
      mreq = '0;
      mreq.wdata = req.data;
      txb = 8'h00; txv = 1'b0; tx_mem_pending = 1'b0;
      rd_rx = 1'b0; rd_tx = 1'b0;
      crc_src = req.data;
      crc_upd = rs485s_pkg::crc_byte(crc_cur, crc_src);
      sum_addr = faddr_ff + {1'b0, req.data};

      if (csr_we && csr_hit) begin
         case (csr_idx)
            rs485s_pkg::CSR_NODE_ADDR: node_in = csr_val;
            rs485s_pkg::CSR_ANS_TMO:   atmo_in = csr_val[7:0];
            rs485s_pkg::CSR_RX_TMO:    rtmo_in = csr_val[7:0];
            default:                   turn_in = csr_val[7:0];
         endcase
      end

      if (go) begin
         case (rs485s_pkg::cmd_type'(req.command))
            rs485s_pkg::CMD_RX_BYTE: begin
               rct_in = rtmo_ff;
               case (rxph_ff)
                  3'd0: begin
                     if (req.data != rs485s_pkg::STX_BYTE) begin
                        rct_in = 8'd0;
                     end else begin
                        crc_in = rs485s_pkg::CRC_INIT;
                        f_forme_in = 1'b0;
                        f_ovr_in = f_proc_ff;
                        rxph_in = 3'd1;
                     end
                  end
                  3'd1: begin
                     f_rxsync_in = req.data[7];
                     faddr_in = {2'b00, req.data[6:0]};
                     rxph_in = 3'd3;
                     if (req.data[6:0] == rs485s_pkg::EXT_ADDR) rxph_in = 3'd2;
                     else if ({2'b00, req.data[6:0]} == node_ff) f_forme_in = 1'b1;
                     crc_in = crc_upd;
                  end
                  3'd2: begin
                     faddr_in = sum_addr;
                     if (sum_addr == node_ff) f_forme_in = 1'b1;
                     rxph_in = 3'd3;
                     crc_in = crc_upd;
                  end
                  3'd3: begin
                     flen_in = req.data;
                     if (f_forme_ff && !f_ovr_ff) acc_in = req.data;
                     crc_in = crc_upd;
                     rxcnt_in = 8'd0;
                     rxph_in = 3'd4;
                  end
                  3'd4: begin
                     if (rxcnt_ff < flen_ff) begin
                        if ({1'b0, rxcnt_ff} < RxD && f_forme_ff && !f_ovr_ff) begin
                           mreq.rx_we = 1'b1;
                           mreq.rx_waddr = rxcnt_ff;
                        end
                        crc_in = crc_upd;
                        rxcnt_in = rxcnt_ff + 8'd1;
                     end else begin
                        rcrc_in = {req.data, 8'h00};
                        rxph_in = 3'd5;
                     end
                  end
                  3'd5: begin
                     rct_in = 8'd0;
                     rcrc_in = rcrc_ff + {8'h00, req.data};
                     rxph_in = 3'd0;
                     if (rcrc_in == crc_cur) begin
                        if (!f_forme_ff) begin
                           f_wait_in = 1'b0;
                        end else if (acc_ff == 8'd0 ||
                                     (f_rxsync_ff == f_sync_ff && !f_proc_ff && !f_valid_ff) ||
                                     (f_rxsync_ff != f_sync_ff && f_ovr_ff)) begin
                           f_wait_in = 1'b0; f_sync_in = 1'b0; f_valid_in = 1'b0;
                           f_abort_in = 1'b1; f_drive_in = 1'b1;
                           wpt_in = (turn_ff != 8'd0) ? turn_ff : 8'd1;
                        end else if (f_rxsync_ff == f_sync_ff) begin
                           if (!f_proc_ff) begin
                              f_drive_in = 1'b1;
                              wpt_in = (turn_ff != 8'd0) ? turn_ff : 8'd1;
                           end
                        end else begin
                           f_sync_in = f_rxsync_ff;
                           f_wait_in = 1'b1;
                           f_valid_in = 1'b0;
                           f_abort_in = 1'b0;
                           ant_in = atmo_ff;
                        end
                     end
                  end
                  default: rxph_in = 3'd0;
               endcase
            end
            rs485s_pkg::CMD_TICK: begin
               if (wpt_ff != 8'd0) begin
                  wpt_in = wpt_ff - 8'd1;
                  if (wpt_ff == 8'd1) begin
                     txph_in = 3'd0;
                     f_txa_in = 1'b1;
                  end
               end
               if (ant_ff != 8'd0) begin
                  ant_in = ant_ff - 8'd1;
                  if (ant_ff == 8'd1) f_wait_in = 1'b0;
               end
               if (rct_ff != 8'd0) begin
                  rct_in = rct_ff - 8'd1;
                  if (rct_ff == 8'd1) rxph_in = 3'd0;
               end
            end
            rs485s_pkg::CMD_POLL: begin
               if (f_wait_ff) f_proc_in = 1'b1;
            end
            rs485s_pkg::CMD_SEND: begin
               f_proc_in = 1'b0;
               if (!f_abort_ff) begin
                  ant_in = 8'd0;
                  alen_in = ({3'b000, req.answer_length} > TxD) ? 6'(TX_DEPTH)
                                                               : req.answer_length;
                  f_valid_in = 1'b1;
                  f_abort_in = 1'b1;
                  if (rxph_ff == 3'd0 && txph_ff == TX_IDLE && f_wait_ff) begin
                     f_drive_in = 1'b1;
                     wpt_in = (turn_ff != 8'd0) ? turn_ff : 8'd1;
                  end
               end
               f_wait_in = 1'b0;
            end
            rs485s_pkg::CMD_TX_RDY: begin
               if (f_txa_ff) begin
                  txv = 1'b1;
                  case (txph_ff)
                     3'd0: begin
                        txb = rs485s_pkg::STX_BYTE;
                        crc_in = rs485s_pkg::CRC_INIT;
                        txph_in = 3'd1;
                     end
                     3'd1: begin
                        txb = f_sync_ff ? 8'h80 : 8'h00;
                        crc_src = txb;
                        crc_upd = rs485s_pkg::crc_byte(crc_cur, crc_src);
                        crc_in = crc_upd;
                        txph_in = 3'd2;
                     end
                     3'd2: begin
                        flen_in = f_valid_ff ? {2'b00, alen_ff} : 8'd0;
                        txb = flen_in;
                        crc_src = txb;
                        crc_upd = rs485s_pkg::crc_byte(crc_cur, crc_src);
                        crc_in = crc_upd;
                        txcnt_in = 6'd0;
                        txph_in = 3'd3;
                     end
                     3'd3: begin
                        if ({2'b00, txcnt_ff} < flen_ff && {3'b000, txcnt_ff} < TxD) begin
                           // byte comes from memory; crc finished in the next cycle
                           mreq.tx_re = 1'b1;
                           mreq.tx_raddr = {2'b00, txcnt_ff};
                           tx_mem_pending = 1'b1;
                           txcnt_in = txcnt_ff + 6'd1;
                        end else begin
                           txb = crc_cur[15:8];
                           txph_in = 3'd4;
                        end
                     end
                     3'd4: begin
                        txb = crc_cur[7:0];
                        txph_in = 3'd5;
                     end
                     3'd5: begin
                        txb = 8'hFF;
                        txph_in = TX_IDLE;
                     end
                     default: begin
                        txv = 1'b0;
                        f_txa_in = 1'b0;
                        f_drive_in = 1'b0;
                     end
                  endcase
               end
            end
            rs485s_pkg::CMD_WR_TX: begin
               if ({4'b0000, req.index} < TxD) begin
                  mreq.tx_we = 1'b1;
                  mreq.tx_waddr = {3'b000, req.index};
               end
            end
            rs485s_pkg::CMD_RD_RX: begin
               if ({4'b0000, req.index} < RxD) begin
                  mreq.rx_re = 1'b1;
                  mreq.rx_raddr = {3'b000, req.index};
                  rd_rx = 1'b1;
               end
            end
            default: ;
         endcase
      end
      rd_tx = tx_mem_pending;

      rsp.tx_byte = txv ? txb : 8'h00;
      rsp.tx_byte_valid = txv;
      rsp.transmitter_active = f_txa_in;
      rsp.bus_drive = f_drive_in;
      rsp.request_waiting = f_wait_in;
      rsp.request_length = acc_in;
      rsp.read_byte = 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= 9'd100; atmo_ff <= 8'd100; rtmo_ff <= 8'd10; turn_ff <= 8'd3;
         rxph_ff <= 3'd0; txph_ff <= TX_IDLE; crc_ff <= rs485s_pkg::CRC_INIT;
         rcrc_ff <= '0; faddr_ff <= '0; flen_ff <= '0; rxcnt_ff <= '0; txcnt_ff <= '0;
         alen_ff <= '0; acc_ff <= '0;
         f_sync_ff <= 1'b0; f_rxsync_ff <= 1'b0; f_forme_ff <= 1'b0; f_ovr_ff <= 1'b0;
         f_wait_ff <= 1'b0; f_proc_ff <= 1'b0; f_valid_ff <= 1'b0; f_abort_ff <= 1'b0;
         f_txa_ff <= 1'b0; f_drive_ff <= 1'b0;
         wpt_ff <= '0; ant_ff <= '0; rct_ff <= '0;
      end else begin
         node_ff <= node_in; atmo_ff <= atmo_in; rtmo_ff <= rtmo_in; turn_ff <= turn_in;
         rxph_ff <= rxph_in; txph_ff <= txph_in; rcrc_ff <= rcrc_in;
         // a payload byte read from memory updates the crc in the following cycle
         crc_ff <= crc_in;
         faddr_ff <= faddr_in; flen_ff <= flen_in; rxcnt_ff <= rxcnt_in;
         txcnt_ff <= txcnt_in; alen_ff <= alen_in; acc_ff <= acc_in;
         f_sync_ff <= f_sync_in; f_rxsync_ff <= f_rxsync_in; f_forme_ff <= f_forme_in;
         f_ovr_ff <= f_ovr_in; f_wait_ff <= f_wait_in; f_proc_ff <= f_proc_in;
         f_valid_ff <= f_valid_in; f_abort_ff <= f_abort_in; f_txa_ff <= f_txa_in;
         f_drive_ff <= f_drive_in;
         wpt_ff <= wpt_in; ant_ff <= ant_in; rct_ff <= rct_in;
      end
   end
endmodule
`default_nettype wire

/* verif/tb_rs485_slave_frame_protocol.sv */
// testbench for the rs485 slave frame engine: sends framed requests, ticks, polls,
// answers and transmit events, and checks every response against an in-bench predictor
// depends on rs485s_pkg and rs485_slave_frame_protocol
`default_nettype none
module tb_rs485_slave_frame_protocol;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 32;
   localparam int CycleLimit = 1500000;
   localparam int ItemTarget = 1500;

   // protocol flag positions
   localparam logic [9:0] FL_SYNC = 10'h001, FL_RXSYNC = 10'h002, FL_FORME = 10'h004,
      FL_OVERRUN = 10'h008, FL_WAITING = 10'h010, FL_PROCESSING = 10'h020,
      FL_VALID = 10'h040, FL_ABORT = 10'h080, FL_TXACTIVE = 10'h100, FL_DRIVE = 10'h200;
   localparam logic [2:0] RX_HUNT = 3'd0, RX_ADDR = 3'd1, RX_EXT = 3'd2, RX_LEN = 3'd3,
      RX_DATA = 3'd4, RX_CRCLO = 3'd5;
   localparam logic [2:0] TX_STX = 3'd0, TX_SYNC = 3'd1, TX_LEN = 3'd2, TX_DATA = 3'd3,
      TX_CRCLO = 3'd4, TX_END = 3'd5, TX_IDLE = 3'd6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_wdata = '0;

   rs485_slave_frame_protocol i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .csr_we, .csr_index, .csr_wdata);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [8:0]  own_addr;
   logic [7:0]  ans_tmo, rx_tmo, turn_ms;
   logic [2:0]  rx_ph, tx_ph;
   logic [15:0] crc_acc, crc_rcvd;
   logic [8:0]  frm_addr;
   logic [7:0]  frm_len, rx_cnt, req_len;
   logic [5:0]  tx_cnt, ans_len;
   logic [9:0]  flags;
   logic [7:0]  turn_tmr, ans_tmr, rx_tmr;
   logic [7:0]  rx_mem [Depth];
   logic [7:0]  tx_mem [Depth];
   logic [Depth-1:0] rx_known;

   rs485s_pkg::rsp_type resp_q[$];
   int items_sent = 0, resp_seen = 0, frames_sent = 0, errors = 0, cycles = 0;
   bit calm = 1'b0;

   function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0};
         if (fb) c = c ^ 16'h1021;
      end
      return c;
   endfunction

   function automatic bit has(logic [9:0] m);
      return (flags & m) != 0;
   endfunction

   function automatic void put_flag(logic [9:0] m, bit v);
      flags = v ? (flags | m) : (flags & ~m);
   endfunction

   function automatic void begin_turnaround();
      flags |= FL_DRIVE;
      turn_tmr = (turn_ms != 0) ? turn_ms : 8'd1;
   endfunction

   function automatic void empty_block();
      flags &= ~(FL_WAITING | FL_SYNC | FL_VALID);
      flags |= FL_ABORT;
      begin_turnaround();
   endfunction

   function automatic void close_frame();
      if (crc_rcvd != crc_acc) return;
      if (!has(FL_FORME)) begin
         flags &= ~FL_WAITING;
         return;
      end
      if (req_len == 0) empty_block();
      else if (has(FL_RXSYNC) == has(FL_SYNC)) begin
         // repeat: resend a valid answer, else an empty block; not while processing
         if (has(FL_PROCESSING)) ;
         else if (!has(FL_VALID)) empty_block();
         else begin_turnaround();
      end else if (has(FL_OVERRUN)) empty_block();
      else begin
         put_flag(FL_SYNC, has(FL_RXSYNC));
         flags |= FL_WAITING;
         flags &= ~(FL_VALID | FL_ABORT);
         ans_tmr = ans_tmo;
      end
   endfunction

   function automatic void take_rx(logic [7:0] ch);
      rx_tmr = rx_tmo;
      case (rx_ph)
         RX_HUNT: begin
            if (ch != rs485s_pkg::STX_BYTE) rx_tmr = 0;
            else begin
               crc_acc = 16'hFFFF;
               flags &= ~FL_FORME;
               put_flag(FL_OVERRUN, has(FL_PROCESSING));
               rx_ph = RX_ADDR;
            end
         end
         RX_ADDR: begin
            put_flag(FL_RXSYNC, ch[7]);
            frm_addr = {2'b0, ch[6:0]};
            rx_ph = RX_LEN;
            if (frm_addr == 9'd126) rx_ph = RX_EXT;
            else if (frm_addr == own_addr) flags |= FL_FORME;
            crc_acc = crc_next(crc_acc, ch);
         end
         RX_EXT: begin
            frm_addr = frm_addr + {1'b0, ch};
            if (frm_addr == own_addr) flags |= FL_FORME;
            rx_ph = RX_LEN;
            crc_acc = crc_next(crc_acc, ch);
         end
         RX_LEN: begin
            frm_len = ch;
            if (has(FL_FORME) && !has(FL_OVERRUN)) req_len = ch;
            crc_acc = crc_next(crc_acc, ch);
            rx_cnt = 0;
            rx_ph = RX_DATA;
         end
         RX_DATA: begin
            if (rx_cnt < frm_len) begin
               if (rx_cnt < Depth && has(FL_FORME) && !has(FL_OVERRUN)) begin
                  rx_mem[rx_cnt[4:0]] = ch;
                  rx_known[rx_cnt[4:0]] = 1'b1;
               end
               crc_acc = crc_next(crc_acc, ch);
               rx_cnt++;
            end else begin
               crc_rcvd = {ch, 8'h00};
               rx_ph = RX_CRCLO;
            end
         end
         RX_CRCLO: begin
            rx_tmr = 0;
            crc_rcvd = crc_rcvd + {8'h00, ch};
            close_frame();
            rx_ph = RX_HUNT;
         end
         default: rx_ph = RX_HUNT;
      endcase
   endfunction

   function automatic void ms_tick();
      if (turn_tmr != 0) begin
         turn_tmr--;
         if (turn_tmr == 0) begin
            tx_ph = TX_STX;
            flags |= FL_TXACTIVE;
         end
      end
      if (ans_tmr != 0) begin
         ans_tmr--;
         if (ans_tmr == 0) flags &= ~FL_WAITING;
      end
      if (rx_tmr != 0) begin
         rx_tmr--;
         if (rx_tmr == 0) rx_ph = RX_HUNT;
      end
   endfunction

   function automatic void post_answer(logic [5:0] len);
      flags &= ~FL_PROCESSING;
      if (!has(FL_ABORT)) begin
         ans_tmr = 0;
         ans_len = (len > Depth) ? 6'(Depth) : len;
         flags |= FL_VALID | FL_ABORT;
         if (rx_ph == RX_HUNT && tx_ph == TX_IDLE && has(FL_WAITING)) begin_turnaround();
      end
      flags &= ~FL_WAITING;
   endfunction

   function automatic bit next_tx(output logic [7:0] ch);
      ch = 0;
      if (!has(FL_TXACTIVE)) return 0;
      case (tx_ph)
         TX_STX: begin
            ch = rs485s_pkg::STX_BYTE;
            crc_acc = 16'hFFFF;
            tx_ph = TX_SYNC;
         end
         TX_SYNC: begin
            ch = has(FL_SYNC) ? 8'h80 : 8'h00;
            crc_acc = crc_next(crc_acc, ch);
            tx_ph = TX_LEN;
         end
         TX_LEN: begin
            frm_len = has(FL_VALID) ? {2'b0, ans_len} : 8'd0;
            ch = frm_len;
            crc_acc = crc_next(crc_acc, ch);
            tx_cnt = 0;
            tx_ph = TX_DATA;
         end
         TX_DATA: begin
            if (tx_cnt < frm_len && tx_cnt < Depth) begin
               ch = tx_mem[tx_cnt[4:0]];
               tx_cnt++;
               crc_acc = crc_next(crc_acc, ch);
            end else begin
               ch = crc_acc[15:8];
               tx_ph = TX_CRCLO;
            end
         end
         TX_CRCLO: begin
            ch = crc_acc[7:0];
            tx_ph = TX_END;
         end
         TX_END: begin
            ch = 8'hFF;
            tx_ph = TX_IDLE;
         end
         default: begin
            flags &= ~(FL_TXACTIVE | FL_DRIVE);
            return 0;
         end
      endcase
      return 1;
   endfunction

   function automatic rs485s_pkg::rsp_type predict_step(rs485s_pkg::cmd_type cmd,
                                                        logic [7:0] data, logic [4:0] idx,
                                                        logic [5:0] alen);
      rs485s_pkg::rsp_type r;
      logic [7:0] b;
      bit sent;
      r = '0;
      sent = 0;
      b = 0;
      case (cmd)
         rs485s_pkg::CMD_RX_BYTE: take_rx(data);
         rs485s_pkg::CMD_TICK:    ms_tick();
         rs485s_pkg::CMD_POLL:    if (has(FL_WAITING)) flags |= FL_PROCESSING;
         rs485s_pkg::CMD_SEND:    post_answer(alen);
         rs485s_pkg::CMD_TX_RDY:  sent = next_tx(b);
         rs485s_pkg::CMD_WR_TX:   tx_mem[idx] = data;
         rs485s_pkg::CMD_RD_RX:   r.read_byte = rx_mem[idx];
         default: ;
      endcase
      r.tx_byte = sent ? b : 8'h00;
      r.tx_byte_valid = sent;
      r.transmitter_active = has(FL_TXACTIVE);
      r.bus_drive = has(FL_DRIVE);
      r.request_waiting = has(FL_WAITING);
      r.request_length = req_len;
      return r;
   endfunction

   task automatic send_item(rs485s_pkg::cmd_type cmd, logic [7:0] data = 0,
                            logic [4:0] idx = 0, logic [5:0] alen = 0);
      if (!calm && $urandom_range(0, 11) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {2'b00, alen, idx, data, cmd};
      do @(posedge clock); while (!req_tready);
      resp_q.push_back(predict_step(cmd, data, idx, alen));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic report(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      $display("mismatch at response %0d: %s got %0h expected %0h", resp_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      rs485s_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (resp_q.size() == 0) begin
            errors++;
            $display("unexpected response %0h", rsp_tdata);
         end else begin
            want = resp_q.pop_front();
            if (rsp_tdata[7:0] !== want.tx_byte) report("tx_byte", rsp_tdata[7:0], want.tx_byte);
            if (rsp_tdata[8] !== want.tx_byte_valid)
               report("tx_byte_valid", rsp_tdata[8], want.tx_byte_valid);
            if (rsp_tdata[9] !== want.transmitter_active)
               report("transmitter_active", rsp_tdata[9], want.transmitter_active);
            if (rsp_tdata[10] !== want.bus_drive)
               report("bus_drive", rsp_tdata[10], want.bus_drive);
            if (rsp_tdata[11] !== want.request_waiting)
               report("request_waiting", rsp_tdata[11], want.request_waiting);
            if (rsp_tdata[19:12] !== want.request_length)
               report("request_length", rsp_tdata[19:12], want.request_length);
            if (rsp_tdata[27:20] !== want.read_byte)
               report("read_byte", rsp_tdata[27:20], want.read_byte);
         end
         resp_seen++;
      end
   end

   // receiver stalls in bursts
   always begin
      @(negedge clock);
      if (!calm && !reset && $urandom_range(0, 9) == 0) begin
         rsp_tready = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      rsp_tready = 1'b1;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic drain();
      req_tvalid = 1'b0;
      while (resp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [8:0] value);
      drain();
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         rs485s_pkg::CSR_NODE_ADDR: own_addr = value;
         rs485s_pkg::CSR_ANS_TMO:   ans_tmo = value[7:0];
         rs485s_pkg::CSR_RX_TMO:    rx_tmo = value[7:0];
         default:                   turn_ms = value[7:0];
      endcase
   endtask

   task automatic set_config(logic [8:0] node, logic [7:0] ans, logic [7:0] rxt,
                             logic [7:0] turn);
      write_reg(rs485s_pkg::CSR_NODE_ADDR, node);
      write_reg(rs485s_pkg::CSR_ANS_TMO, {1'b0, ans});
      write_reg(rs485s_pkg::CSR_RX_TMO, {1'b0, rxt});
      write_reg(rs485s_pkg::CSR_TURN, {1'b0, turn});
   endtask

   // one frame on the line; station addresses from 126 up use the extended form
   task automatic send_frame(logic [8:0] dest, bit sync, logic [7:0] len, bit bad_crc,
                             bit noisy = 0);
      logic [15:0] c;
      logic [7:0] b;
      c = 16'hFFFF;
      frames_sent++;
      send_item(rs485s_pkg::CMD_RX_BYTE, rs485s_pkg::STX_BYTE);
      if (dest >= 126) begin
         b = {sync, rs485s_pkg::EXT_ADDR};
         c = crc_next(c, b);
         send_item(rs485s_pkg::CMD_RX_BYTE, b);
         b = 8'(dest - 9'd126);
      end else b = {sync, dest[6:0]};
      c = crc_next(c, b);
      send_item(rs485s_pkg::CMD_RX_BYTE, b);
      c = crc_next(c, len);
      send_item(rs485s_pkg::CMD_RX_BYTE, len);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         c = crc_next(c, b);
         send_item(rs485s_pkg::CMD_RX_BYTE, b);
         if (noisy && $urandom_range(0, 15) == 0) send_item(rs485s_pkg::CMD_TICK);
      end
      if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
      send_item(rs485s_pkg::CMD_RX_BYTE, c[15:8]);
      send_item(rs485s_pkg::CMD_RX_BYTE, c[7:0]);
   endtask

   // run the turnaround delay out and clock the answer onto the line
   task automatic play_answer();
      int guard;
      guard = 0;
      while (turn_tmr != 0 && guard < 300) begin
         send_item(rs485s_pkg::CMD_TICK);
         guard++;
      end
      guard = 0;
      while (has(FL_TXACTIVE) && guard < 60) begin
         send_item(rs485s_pkg::CMD_TX_RDY);
         guard++;
      end
   endtask

   task automatic read_rx_item();
      logic [4:0] idx;
      idx = 5'($urandom);
      if (!rx_known[idx]) begin
         if (rx_known == 0) return;
         while (!rx_known[idx]) idx++;
      end
      send_item(rs485s_pkg::CMD_RD_RX, 8'($urandom), idx, 6'($urandom));
   endtask

   task automatic exchange(bit noisy);
      logic [8:0] dest;
      logic [7:0] len;
      bit sync;
      dest = ($urandom_range(0, 3) != 0) ? own_addr : 9'($urandom_range(0, 381));
      sync = ($urandom_range(0, 4) != 0) ? !has(FL_SYNC) : has(FL_SYNC);
      len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 48)) : 8'($urandom_range(0, 8));
      send_frame(dest, sync, len, $urandom_range(0, 11) == 0, noisy);
      if ($urandom_range(0, 2) != 0)
         send_item(rs485s_pkg::CMD_POLL, 8'($urandom), 5'($urandom));
      repeat ($urandom_range(0, 4)) read_rx_item();
      repeat ($urandom_range(0, 6))
         send_item(rs485s_pkg::CMD_WR_TX, 8'($urandom), 5'($urandom), 6'($urandom));
      if (noisy) repeat ($urandom_range(0, 3)) send_item(rs485s_pkg::CMD_TICK);
      if ($urandom_range(0, 7) != 0)
         send_item(rs485s_pkg::CMD_SEND, 8'($urandom), 5'($urandom),
                   ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8)));
      play_answer();
   endtask

   // random command; receive buffer reads only go to entries already written
   task automatic noise_item();
      rs485s_pkg::cmd_type cmd;
      logic [4:0] idx;
      cmd = rs485s_pkg::cmd_type'($urandom_range(0, 7));
      idx = 5'($urandom);
      if (cmd == rs485s_pkg::CMD_RD_RX && !rx_known[idx]) begin
         if (rx_known == '0) cmd = rs485s_pkg::CMD_NOP;
         else while (!rx_known[idx]) idx++;
      end
      send_item(cmd, 8'($urandom), idx, 6'($urandom));
   endtask

   task automatic test_directed();
      for (int i = 0; i < Depth; i++)
         send_item(rs485s_pkg::CMD_WR_TX, (i == 0) ? 8'h00 : 8'hFF - 8'(i), 5'(i));
      send_item(rs485s_pkg::CMD_NOP, 8'hFF, 5'h1F, 6'h3F);
      send_item(rs485s_pkg::CMD_TX_RDY);                      // transmitter not running
      send_item(rs485s_pkg::CMD_SEND, 8'h00, 5'h00, 6'h05);   // answer with no request open
      send_frame(own_addr, 1'b1, 8'd3, 1'b0);                 // new request
      send_item(rs485s_pkg::CMD_RD_RX, 8'h00, 5'd2);
      send_item(rs485s_pkg::CMD_POLL);
      send_frame(own_addr, 1'b1, 8'd3, 1'b0);                 // repeat while still processing
      send_item(rs485s_pkg::CMD_SEND, 8'h00, 5'h00, 6'h3F);   // long answer saturates
      play_answer();
      send_frame(own_addr, 1'b1, 8'd2, 1'b0);                 // repeat asks for the answer again
      play_answer();
      send_frame(own_addr, 1'b0, 8'd0, 1'b0);                 // empty block resync
      play_answer();
      send_frame(9'd200, 1'b1, 8'd40, 1'b0);                  // foreign long frame
      send_frame(own_addr, 1'b1, 8'd40, 1'b0);                // long payload past the buffer
      send_frame(own_addr, 1'b0, 8'd1, 1'b1);                 // bad crc
      send_item(rs485s_pkg::CMD_RD_RX, 8'h00, 5'd31);
      send_item(rs485s_pkg::CMD_SEND, 8'h00, 5'h00, 6'd32);
      play_answer();
      send_item(rs485s_pkg::CMD_RX_BYTE, rs485s_pkg::STX_BYTE); // frame cut by receive timeout
      send_item(rs485s_pkg::CMD_RX_BYTE, 8'h80 | 8'(own_addr));
      repeat (12) send_item(rs485s_pkg::CMD_TICK);
   endtask

   task automatic test_config_sweep();
      set_config(9'd0, 8'd1, 8'd1, 8'd1);
      repeat (8) exchange(1);
      set_config(9'd381, 8'd255, 8'd255, 8'd255);
      repeat (1) exchange(0);
      set_config(9'd126, 8'd0, 8'd0, 8'd0);
      repeat (8) exchange(1);
      set_config(9'd511, 8'd3, 8'd2, 8'd2);
      repeat (4) exchange(1);
      set_config(9'd5, 8'd20, 8'd6, 8'd2);
      repeat (8) exchange(1);
   endtask

   task automatic test_random();
      while (items_sent < ItemTarget) begin
         if (items_sent > ItemTarget * 85 / 100) calm = 1'b1;
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) noise_item();
         else exchange($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 25) == 0)
            set_config(9'($urandom_range(0, 381)), 8'($urandom_range(1, 40)),
                       8'($urandom_range(1, 12)), 8'($urandom_range(1, 6)));
      end
   endtask

   initial begin
      own_addr = 9'd100; ans_tmo = 8'd100; rx_tmo = 8'd10; turn_ms = 8'd3;
      rx_ph = RX_HUNT; tx_ph = TX_IDLE; crc_acc = 16'hFFFF; crc_rcvd = 0;
      frm_addr = 0; frm_len = 0; rx_cnt = 0; tx_cnt = 0; req_len = 0; ans_len = 0;
      flags = 0; turn_tmr = 0; ans_tmr = 0; rx_tmr = 0; rx_known = '0;
      for (int i = 0; i < Depth; i++) begin
         rx_mem[i] = 0;
         tx_mem[i] = 0;
      end
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_sweep();
      test_random();
      req_tvalid = 1'b0;
      while (resp_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("sent %0d items in %0d frames, checked %0d responses, %0d mismatches",
               items_sent, frames_sent, resp_seen, errors);
      if (errors == 0 && resp_q.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
hw/rtl/rs485s_pkg.sv
hw/rtl/rs485s_bufs.sv
hw/rtl/rs485s_engine.sv
hw/rtl/rs485_slave_frame_protocol.sv
verif/tb_rs485_slave_frame_protocol.sv
